// File: hw/rtl/mandelstam_st_histogram_defines.svh
// Assertion macros used by the RTL controller.
`ifndef MANDELSTAM_ST_HISTOGRAM_DEFINES_SVH
`define MANDELSTAM_ST_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSTH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/msth_pkg.sv
package msth_pkg;

  localparam int S_BINS      = 5;
  localparam int T_BINS      = 10;
  localparam int COUNT_WIDTH = 32;
  localparam int NBINS       = S_BINS * T_BINS;
  localparam int ADDR_W      = (NBINS > 1) ? $clog2(NBINS) : 1;

  localparam int COMP_W      = 24;
  localparam int SUM_W       = 25;
  localparam int PROD_W      = 50;
  localparam int MAG_W       = 52;
  localparam int OUT_COUNT_W = 32;
  localparam int S_BIN_W     = 3;
  localparam int T_BIN_W     = 4;

  localparam logic [1:0] OP_LOAD_BEAM  = 2'd0;
  localparam logic [1:0] OP_LOAD_MESON = 2'd1;
  localparam logic [1:0] OP_EVENT      = 2'd2;
  localparam logic [1:0] OP_DUMP       = 2'd3;

  typedef logic signed [MAG_W-1:0] mag_t;
  typedef logic signed [COMP_W-1:0] comp_t;

  localparam mag_t S_EDGES [0:5] = '{
    52'sd21474836480, 52'sd42949672960, 52'sd64424509440,
    52'sd85899345920, 52'sd107374182400, 52'sd128849018880
  };

  localparam mag_t T_EDGES [0:10] = '{
    52'sd0, 52'sd429496730, 52'sd858993459, 52'sd1288490189,
    52'sd1717986918, 52'sd2147483648, 52'sd3006477107,
    52'sd4294967296, 52'sd6442450944, 52'sd8589934592,
    52'sd12884901888
  };

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [COMP_W-1:0] energy;
    logic signed [COMP_W-1:0] mom_x;
    logic signed [COMP_W-1:0] mom_y;
    logic signed [COMP_W-1:0] mom_z;
  } item_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] bin_count;
    logic [S_BIN_W-1:0]     s_bin;
    logic [T_BIN_W-1:0]     t_bin;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic              load_beam;
    logic              load_meson;
    logic              load_baryon;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic              acc_en;
    logic              acc_first;
    logic              bin_en;
    logic              rd_en;
    logic              rd_dump;
    logic [ADDR_W-1:0] dump_addr;
    logic [S_BIN_W-1:0] s_bin;
    logic [T_BIN_W-1:0] t_bin;
    logic              last;
    logic              wr_en;
  } cmd_t;

endpackage

// File: hw/rtl/msth_ctrl.sv
`include "mandelstam_st_histogram_defines.svh"

module msth_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          opcode,
  output logic                busy,
  output msth_pkg::cmd_t      cmd
);

  localparam logic [2:0] IDLE  = 3'd0;
  localparam logic [2:0] MUL   = 3'd1;
  localparam logic [2:0] ACC   = 3'd2;
  localparam logic [2:0] BIN   = 3'd3;
  localparam logic [2:0] READ  = 3'd4;
  localparam logic [2:0] WRITE = 3'd5;
  localparam logic [2:0] DUMP  = 3'd6;

  logic [2:0]                    state;
  logic [1:0]                    k;
  logic [msth_pkg::S_BIN_W-1:0]  s_cnt;
  logic [msth_pkg::T_BIN_W-1:0]  t_cnt;
  logic                          accept;
  logic                          s_end;
  logic                          t_end;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;
  assign s_end  = (s_cnt == msth_pkg::S_BIN_W'(msth_pkg::S_BINS - 1));
  assign t_end  = (t_cnt == msth_pkg::T_BIN_W'(msth_pkg::T_BINS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      k     <= '0;
      s_cnt <= '0;
      t_cnt <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            case (opcode)
              msth_pkg::OP_EVENT: begin
                state <= MUL;
                k     <= '0;
              end
              msth_pkg::OP_DUMP: begin
                state <= DUMP;
                s_cnt <= '0;
                t_cnt <= '0;
              end
              default: ;
            endcase
          end
        end
        MUL: begin
          k <= k + 2'd1;
          if (k == 2'd3) state <= ACC;
        end
        ACC:   state <= BIN;
        BIN:   state <= READ;
        READ:  state <= WRITE;
        WRITE: state <= IDLE;
        DUMP: begin
          if (t_end) begin
            t_cnt <= '0;
            if (s_end) state <= IDLE;
            else s_cnt <= s_cnt + 1'b1;
          end else begin
            t_cnt <= t_cnt + 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.load_beam   = accept && (opcode == msth_pkg::OP_LOAD_BEAM);
    cmd.load_meson  = accept && (opcode == msth_pkg::OP_LOAD_MESON);
    cmd.load_baryon = accept && (opcode == msth_pkg::OP_EVENT);
    cmd.mul_en      = (state == MUL);
    cmd.mul_sel     = k;
    cmd.acc_en      = ((state == MUL) && (k != 2'd0)) || (state == ACC);
    cmd.acc_first   = (state == MUL) && (k == 2'd1);
    cmd.bin_en      = (state == BIN);
    cmd.rd_en       = (state == READ) || (state == DUMP);
    cmd.rd_dump     = (state == DUMP);
    cmd.dump_addr   = msth_pkg::ADDR_W'(s_cnt * msth_pkg::T_BINS + t_cnt);
    cmd.s_bin       = s_cnt;
    cmd.t_bin       = t_cnt;
    cmd.last        = s_end && t_end;
    cmd.wr_en       = (state == WRITE);
  end

  `MSTH_ASSERT_NEXT(a_event_starts_mul, clk, rst,
    accept && (opcode == msth_pkg::OP_EVENT), (state == MUL) && (k == 2'd0),
    "event transaction did not start the multiply sequence")
  `MSTH_ASSERT_NEXT(a_mul_ends_in_acc, clk, rst,
    (state == MUL) && (k == 2'd3), state == ACC,
    "multiply sequence did not end in accumulate")
  `MSTH_ASSERT_NEXT(a_dump_ends_idle, clk, rst,
    (state == DUMP) && s_end && t_end, state == IDLE,
    "dump did not return to idle after the final bin")

endmodule

// File: hw/rtl/msth_datapath.sv
module msth_datapath (
  input  logic                clk,
  input  logic                rst,
  input  msth_pkg::item_t     item,
  input  msth_pkg::cmd_t      cmd,
  output msth_pkg::result_t   result,
  output logic                strobe
);

  msth_pkg::comp_t beam   [0:3];
  msth_pkg::comp_t meson  [0:3];
  msth_pkg::comp_t baryon [0:3];
  msth_pkg::comp_t item_v [0:3];

  logic signed [msth_pkg::SUM_W-1:0]  sum_k;
  logic signed [msth_pkg::SUM_W-1:0]  dif_k;
  logic signed [msth_pkg::PROD_W-1:0] prod_s;
  logic signed [msth_pkg::PROD_W-1:0] prod_t;
  msth_pkg::mag_t                     acc_s;
  msth_pkg::mag_t                     acc_t;

  logic                              s_hit;
  logic                              t_hit;
  logic [msth_pkg::S_BIN_W-1:0]      s_idx;
  logic [msth_pkg::T_BIN_W-1:0]      t_idx;
  logic                              hit;
  logic [msth_pkg::S_BIN_W-1:0]      s_idx_r;
  logic [msth_pkg::T_BIN_W-1:0]      t_idx_r;
  logic [msth_pkg::ADDR_W-1:0]       bin_addr;
  logic [msth_pkg::ADDR_W-1:0]       rd_addr;

  logic [msth_pkg::COUNT_WIDTH-1:0]  mem [0:msth_pkg::NBINS-1];
  logic [msth_pkg::NBINS-1:0]        valid;
  logic [msth_pkg::COUNT_WIDTH-1:0]  rd_data;
  logic                              rd_valid;
  logic [msth_pkg::COUNT_WIDTH-1:0]  cur_count;
  logic [msth_pkg::COUNT_WIDTH-1:0]  inc_val;

  logic [msth_pkg::S_BIN_W-1:0]      tag_s;
  logic [msth_pkg::T_BIN_W-1:0]      tag_t;
  logic                              tag_last;

  assign item_v[0] = item.energy;
  assign item_v[1] = item.mom_x;
  assign item_v[2] = item.mom_y;
  assign item_v[3] = item.mom_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        beam[i]  <= '0;
        meson[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (cmd.load_beam)  beam[i]  <= item_v[i];
        if (cmd.load_meson) meson[i] <= item_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_baryon) begin
      for (int i = 0; i < 4; i++) baryon[i] <= item_v[i];
    end
  end

  assign sum_k = msth_pkg::SUM_W'(meson[cmd.mul_sel]) + msth_pkg::SUM_W'(baryon[cmd.mul_sel]);
  assign dif_k = msth_pkg::SUM_W'(beam[cmd.mul_sel]) - msth_pkg::SUM_W'(meson[cmd.mul_sel]);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_s <= sum_k * sum_k;
      prod_t <= dif_k * dif_k;
    end
    if (cmd.acc_en) begin
      if (cmd.acc_first) begin
        acc_s <= msth_pkg::MAG_W'(prod_s);
        acc_t <= -msth_pkg::MAG_W'(prod_t);
      end else begin
        acc_s <= acc_s - msth_pkg::MAG_W'(prod_s);
        acc_t <= acc_t + msth_pkg::MAG_W'(prod_t);
      end
    end
  end

  always_comb begin
    s_hit = 1'b0;
    s_idx = '0;
    for (int i = 0; i < msth_pkg::S_BINS; i++) begin
      if (acc_s >= msth_pkg::S_EDGES[i] && acc_s < msth_pkg::S_EDGES[i+1]) begin
        s_hit = 1'b1;
        s_idx = msth_pkg::S_BIN_W'(i);
      end
    end
    t_hit = 1'b0;
    t_idx = '0;
    for (int j = 0; j < msth_pkg::T_BINS; j++) begin
      if (acc_t >= msth_pkg::T_EDGES[j] && acc_t < msth_pkg::T_EDGES[j+1]) begin
        t_hit = 1'b1;
        t_idx = msth_pkg::T_BIN_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.bin_en) begin
      hit <= s_hit && t_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_en) begin
      s_idx_r <= s_idx;
      t_idx_r <= t_idx;
    end
  end

  assign bin_addr  = msth_pkg::ADDR_W'(s_idx_r * msth_pkg::T_BINS + t_idx_r);
  assign rd_addr   = cmd.rd_dump ? cmd.dump_addr : bin_addr;
  assign cur_count = rd_valid ? rd_data : '0;
  assign inc_val   = (&cur_count) ? cur_count : cur_count + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && hit) mem[bin_addr] <= inc_val;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      if (cmd.wr_en && hit) valid[bin_addr] <= 1'b1;
      if (cmd.rd_en) rd_valid <= valid[rd_addr];
      strobe <= cmd.rd_en && cmd.rd_dump;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en && cmd.rd_dump) begin
      tag_s    <= cmd.s_bin;
      tag_t    <= cmd.t_bin;
      tag_last <= cmd.last;
    end
  end

  always_comb begin
    result.bin_count = msth_pkg::OUT_COUNT_W'(cur_count);
    result.s_bin     = tag_s;
    result.t_bin     = tag_t;
    result.last      = tag_last;
  end

endmodule

// File: hw/rtl/mandelstam_st_histogram.sv
// Load beam or meson: captured on the accepting edge, busy stays low.
// Event: busy from the accepting edge through 4 multiply steps on a shared squarer pair,
// accumulate, bin compare, counter read and counter write; start is taken only when idle.
// Dump: 50 results on consecutive cycles via registered counter reads; busy through the dump.
// Results cannot be stalled: each is valid for exactly one cycle under strobe.
// Synchronous rst clears the beam and meson vectors and all counters (per-bin valid flags).
module mandelstam_st_histogram (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  msth_pkg::item_t     item,
  output msth_pkg::result_t   result,
  output logic                strobe
);

  msth_pkg::cmd_t cmd;

  msth_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .busy   (busy),
    .cmd    (cmd)
  );

  msth_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .result (result),
    .strobe (strobe)
  );

endmodule
